/* src/usb_pd_message_state_machine_core_defines.svh */
// Assertion macros used by the checker file of the PD protocol layer.
// No dependencies; the file is taken in by `include.
`ifndef USB_PD_MESSAGE_STATE_MACHINE_CORE_DEFINES_SVH
`define USB_PD_MESSAGE_STATE_MACHINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UPD_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UPD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/upd_msm_pkg.sv */
// Types, codes and header builder of the PD protocol layer.
// No dependencies; used by the core and its checker.
`timescale 1ns / 1ps

package upd_msm_pkg;

    localparam int PORT_COUNT = 2;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = 2;
    localparam int RES_CNT_W  = 3;

    // event kinds
    localparam logic [1:0] KIND_RX      = 2'd0;
    localparam logic [1:0] KIND_CC      = 2'd1;
    localparam logic [1:0] KIND_HRESET  = 2'd2;
    localparam logic [1:0] KIND_SEND    = 2'd3;

    // control message types
    localparam logic [4:0] CT_ACCEPT        = 5'd3;
    localparam logic [4:0] CT_REJECT        = 5'd4;
    localparam logic [4:0] CT_PS_RDY        = 5'd6;
    localparam logic [4:0] CT_DR_SWAP       = 5'd9;
    localparam logic [4:0] CT_PR_SWAP       = 5'd10;
    localparam logic [4:0] CT_SOFT_RESET    = 5'd13;
    localparam logic [4:0] CT_NOT_SUPPORTED = 5'd16;

    // data message types
    localparam logic [4:0] DT_SOURCE_CAP = 5'd1;
    localparam logic [4:0] DT_REQUEST    = 5'd2;
    localparam logic [4:0] DT_VDM        = 5'd15;

    // contract states
    localparam logic [3:0] CS_IDLE       = 4'd0;
    localparam logic [3:0] CS_CAPS       = 4'd1;
    localparam logic [3:0] CS_REQUEST    = 4'd2;
    localparam logic [3:0] CS_ACCEPT     = 4'd3;
    localparam logic [3:0] CS_PS_RDY     = 4'd4;
    localparam logic [3:0] CS_ACTIVE     = 4'd6;
    localparam logic [3:0] CS_HARD_RESET = 4'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_FORWARD_ENABLE = 2'd0;
    localparam logic [1:0] CFG_ROUTING_MODE   = 2'd1;
    localparam logic [1:0] CFG_COVERT_COMMAND = 2'd2;

    localparam logic [1:0] ROUTE_PASSTHROUGH = 2'd0;
    localparam logic [1:0] SPEC_REV          = 2'd2;

    // reset roles: port 0 source/DFP, port 1 sink/UFP (bit i = port i)
    localparam logic [PORT_COUNT-1:0] ROLE_RESET = 2'b01;

    typedef struct packed {
        logic [1:0]  kind;
        logic        port;
        logic [15:0] rx_header;
        logic [6:0]  vdm_command;
        logic        cc_attached;
        logic [4:0]  control_type;
    } item_t;

    typedef struct packed {
        logic        tx_valid;
        logic        tx_port;
        logic [15:0] tx_header;
        logic        copy_payload;
        logic        vbus_enable;
        logic        vbus_cut;
        logic        hard_reset_cmd;
        logic        covert_valid;
        logic [2:0]  covert_count;
        logic [3:0]  port_contract;
        logic        last;
    } result_t;

    function automatic logic [15:0] make_header(
        input logic [4:0] hdr_type,
        input logic       prole,
        input logic       drole,
        input logic [2:0] msg_id,
        input logic [2:0] nobj
    );
        make_header = {1'b0, nobj, msg_id, prole, SPEC_REV, drole, hdr_type};
    endfunction

endpackage

/* src/usb_pd_message_state_machine_core.sv */
// Two-port USB PD protocol layer: event decode, per-port state, result queue.
// Depends on upd_msm_pkg.
`timescale 1ns / 1ps
//
//  channel   signals                                  direction  transfer when
//  ------    ---------------------------------------  ---------  ------------------------
//  event     item_valid, item_ready, item (item_t)    in         item_valid && item_ready
//  result    result_valid, result_ready, result       out        result_valid && result_ready
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in        cfg_valid && cfg_ready
//
//  An event transfer lands in the stage register and is decoded against the per-port state;
//  once the queue has room, one or two results are written into a 4-entry result queue.
//  The first result reaches the result port through the stage register and the result queue.
//  Sustained rate: one event per cycle while results drain and the queue has room; set by
//  the result port, which moves one result per cycle, so two-result events back up the queue.
//  Reset (rst_n low, async) returns all control and per-port state to reset values; no clearing pass.
//  A stalled result port fills the queue; once it holds more than two results the stage holds and item_ready drops.
//  cfg_ready is always high.

module usb_pd_message_state_machine_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  upd_msm_pkg::item_t       item,
    output logic                     result_valid,
    input  logic                     result_ready,
    output upd_msm_pkg::result_t     result,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [6:0]               cfg_data
);

    // configuration
    logic       forward_enable_reg;
    logic [1:0] routing_mode_reg;
    logic [6:0] covert_command_reg;

    // per-port protocol state
    logic [3:0] contract_reg [upd_msm_pkg::PORT_COUNT];
    logic [3:0] contract_next [upd_msm_pkg::PORT_COUNT];
    logic [2:0] tx_id_reg [upd_msm_pkg::PORT_COUNT];
    logic [2:0] tx_id_next [upd_msm_pkg::PORT_COUNT];
    logic [2:0] rx_id_reg [upd_msm_pkg::PORT_COUNT];
    logic [2:0] rx_id_next [upd_msm_pkg::PORT_COUNT];
    logic [upd_msm_pkg::PORT_COUNT-1:0] rx_id_valid_reg, rx_id_valid_next;
    logic [upd_msm_pkg::PORT_COUNT-1:0] power_role_reg, power_role_next;
    logic [upd_msm_pkg::PORT_COUNT-1:0] data_role_reg, data_role_next;

    // stage register
    upd_msm_pkg::item_t stage_reg;
    logic               stage_valid_reg;
    logic               stage_fire;

    // result queue
    upd_msm_pkg::result_t               queue_reg [upd_msm_pkg::RES_DEPTH];
    logic [upd_msm_pkg::RES_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [upd_msm_pkg::RES_CNT_W-1:0]  count_reg, count_next;
    logic [1:0]                         push_n;
    logic                               pop;

    // decode
    upd_msm_pkg::result_t res0, res1;
    logic                 two_results;
    logic                 p, other;
    logic [4:0]           rx_type;
    logic [2:0]           nobj, msg_id;
    logic                 dup, fwd;
    logic                 new_prole, new_drole;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_enable_reg <= 1'b1;
            routing_mode_reg   <= '0;
            covert_command_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                upd_msm_pkg::CFG_FORWARD_ENABLE: forward_enable_reg <= cfg_data[0];
                upd_msm_pkg::CFG_ROUTING_MODE:   routing_mode_reg   <= cfg_data[1:0];
                upd_msm_pkg::CFG_COVERT_COMMAND: covert_command_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage advances only when the queue has room for two results.
    assign stage_fire = stage_valid_reg && (count_reg <= 3'd2);
    assign item_ready = !stage_valid_reg || stage_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_reg <= item;
    end

    // Event decode against current state.
    always_comb
    begin
        p         = stage_reg.port;
        other     = ~stage_reg.port;
        rx_type   = stage_reg.rx_header[4:0];
        nobj      = stage_reg.rx_header[14:12];
        msg_id    = stage_reg.rx_header[11:9];
        fwd       = forward_enable_reg
                    && (routing_mode_reg == upd_msm_pkg::ROUTE_PASSTHROUGH);
        dup       = rx_id_valid_reg[p] && (rx_id_reg[p] == msg_id);
        new_prole = ~power_role_reg[p];
        new_drole = ~data_role_reg[p];

        contract_next     = contract_reg;
        tx_id_next        = tx_id_reg;
        rx_id_next        = rx_id_reg;
        rx_id_valid_next  = rx_id_valid_reg;
        power_role_next   = power_role_reg;
        data_role_next    = data_role_reg;
        res0              = '0;
        res1              = '0;
        two_results       = 1'b0;

        case (stage_reg.kind)
            upd_msm_pkg::KIND_RX:
            begin
                if (!dup)
                begin
                    rx_id_valid_next[p] = 1'b1;
                    rx_id_next[p]       = msg_id;
                    if (nobj == 3'd0)
                    begin
                        case (rx_type)
                            upd_msm_pkg::CT_ACCEPT:
                                contract_next[p] = upd_msm_pkg::CS_ACCEPT;
                            upd_msm_pkg::CT_PS_RDY:
                            begin
                                if (contract_reg[p] == upd_msm_pkg::CS_ACCEPT)
                                begin
                                    contract_next[p] = upd_msm_pkg::CS_PS_RDY;
                                    res0.vbus_enable = 1'b1;
                                end
                            end
                            upd_msm_pkg::CT_REJECT, upd_msm_pkg::CT_NOT_SUPPORTED:
                                contract_next[p] = upd_msm_pkg::CS_IDLE;
                            upd_msm_pkg::CT_SOFT_RESET:
                                tx_id_next[p] = '0;
                            upd_msm_pkg::CT_PR_SWAP:
                            begin
                                power_role_next[p] = new_prole;
                                res0.tx_valid  = 1'b1;
                                res0.tx_port   = p;
                                res0.tx_header = upd_msm_pkg::make_header(
                                    upd_msm_pkg::CT_ACCEPT, new_prole, data_role_reg[p],
                                    tx_id_reg[p], 3'd0);
                                tx_id_next[p]  = tx_id_reg[p] + 3'd1;
                            end
                            upd_msm_pkg::CT_DR_SWAP:
                            begin
                                data_role_next[p] = new_drole;
                                res0.tx_valid  = 1'b1;
                                res0.tx_port   = p;
                                res0.tx_header = upd_msm_pkg::make_header(
                                    upd_msm_pkg::CT_ACCEPT, power_role_reg[p], new_drole,
                                    tx_id_reg[p], 3'd0);
                                tx_id_next[p]  = tx_id_reg[p] + 3'd1;
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (rx_type)
                            upd_msm_pkg::DT_SOURCE_CAP:
                            begin
                                contract_next[p] = upd_msm_pkg::CS_CAPS;
                                if (fwd)
                                begin
                                    // forwarded caps always claim source/DFP roles
                                    res0.tx_valid     = 1'b1;
                                    res0.tx_port      = other;
                                    res0.tx_header    = upd_msm_pkg::make_header(
                                        upd_msm_pkg::DT_SOURCE_CAP, 1'b1, 1'b1,
                                        tx_id_reg[other], nobj);
                                    res0.copy_payload = 1'b1;
                                    tx_id_next[other] = tx_id_reg[other] + 3'd1;
                                end
                            end
                            upd_msm_pkg::DT_REQUEST:
                            begin
                                contract_next[p] = upd_msm_pkg::CS_REQUEST;
                                if (fwd)
                                begin
                                    res0.tx_valid     = 1'b1;
                                    res0.tx_port      = other;
                                    res0.tx_header    = upd_msm_pkg::make_header(
                                        upd_msm_pkg::DT_REQUEST, power_role_reg[other],
                                        data_role_reg[other], tx_id_reg[other], nobj);
                                    res0.copy_payload = 1'b1;
                                    tx_id_next[other] = tx_id_reg[other] + 3'd1;
                                    res1.tx_valid     = 1'b1;
                                    res1.tx_port      = p;
                                    res1.tx_header    = upd_msm_pkg::make_header(
                                        upd_msm_pkg::CT_ACCEPT, power_role_reg[p],
                                        data_role_reg[p], tx_id_reg[p], 3'd0);
                                    tx_id_next[p]     = tx_id_reg[p] + 3'd1;
                                    two_results       = 1'b1;
                                end
                                else
                                begin
                                    res0.tx_valid  = 1'b1;
                                    res0.tx_port   = p;
                                    res0.tx_header = upd_msm_pkg::make_header(
                                        upd_msm_pkg::CT_ACCEPT, power_role_reg[p],
                                        data_role_reg[p], tx_id_reg[p], 3'd0);
                                    tx_id_next[p]  = tx_id_reg[p] + 3'd1;
                                end
                            end
                            upd_msm_pkg::DT_VDM:
                            begin
                                if ((stage_reg.vdm_command == covert_command_reg)
                                    && (nobj > 3'd1))
                                begin
                                    res0.covert_valid = 1'b1;
                                    res0.covert_count = nobj - 3'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            upd_msm_pkg::KIND_CC:
            begin
                if (!stage_reg.cc_attached
                    && (contract_reg[p] == upd_msm_pkg::CS_ACTIVE))
                begin
                    contract_next[p] = upd_msm_pkg::CS_IDLE;
                    res0.vbus_cut    = 1'b1;
                end
            end
            upd_msm_pkg::KIND_HRESET:
            begin
                res0.hard_reset_cmd = 1'b1;
                res0.vbus_cut       = 1'b1;
                contract_next[p]    = upd_msm_pkg::CS_HARD_RESET;
            end
            default:
            begin
                // local control message send, type taken as given
                res0.tx_valid  = 1'b1;
                res0.tx_port   = p;
                res0.tx_header = upd_msm_pkg::make_header(
                    stage_reg.control_type, power_role_reg[p], data_role_reg[p],
                    tx_id_reg[p], 3'd0);
                tx_id_next[p]  = tx_id_reg[p] + 3'd1;
            end
        endcase

        res0.port_contract = contract_next[p];
        res1.port_contract = contract_next[p];
        res0.last          = !two_results;
        res1.last          = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < upd_msm_pkg::PORT_COUNT; i++)
            begin
                contract_reg[i] <= upd_msm_pkg::CS_IDLE;
                tx_id_reg[i]    <= '0;
                rx_id_reg[i]    <= '0;
            end
            rx_id_valid_reg <= '0;
            power_role_reg  <= upd_msm_pkg::ROLE_RESET;
            data_role_reg   <= upd_msm_pkg::ROLE_RESET;
        end
        else if (stage_fire)
        begin
            contract_reg    <= contract_next;
            tx_id_reg       <= tx_id_next;
            rx_id_reg       <= rx_id_next;
            rx_id_valid_reg <= rx_id_valid_next;
            power_role_reg  <= power_role_next;
            data_role_reg   <= data_role_next;
        end
    end

    // Result queue
    assign push_n     = stage_fire ? (two_results ? 2'd2 : 2'd1) : 2'd0;
    assign pop        = result_valid && result_ready;
    assign count_next = count_reg + {1'b0, push_n} - {2'b00, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_n;
            rd_ptr_reg <= rd_ptr_reg + {1'b0, pop};
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            queue_reg[wr_ptr_reg] <= res0;
            if (two_results)
                queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    assign result_valid = (count_reg != '0);
    assign result       = queue_reg[rd_ptr_reg];

endmodule

/* src/upd_msm_checker.sv */
// Port-level checks of the PD protocol layer, bound to the core.
// Depends on upd_msm_pkg and usb_pd_message_state_machine_core_defines.svh.
`timescale 1ns / 1ps
`include "usb_pd_message_state_machine_core_defines.svh"

module upd_msm_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input upd_msm_pkg::result_t result
);

    logic out_xfer;
    assign out_xfer = result_valid && result_ready;

    `UPD_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `UPD_ASSERT_NOW(a_no_tx_zero, out_xfer && !result.tx_valid, (result.tx_port == 1'b0) && (result.tx_header == 16'h0000) && !result.copy_payload, "transmit fields set without tx_valid")
    `UPD_ASSERT_NOW(a_covert_zero, out_xfer && !result.covert_valid, result.covert_count == 3'd0, "covert count without covert_valid")
    `UPD_ASSERT_NOW(a_hdr_layout, out_xfer && result.tx_valid, (result.tx_header[7:6] == upd_msm_pkg::SPEC_REV) && !result.tx_header[15], "bad transmit header layout")
    `UPD_ASSERT_NOW(a_first_is_fwd, out_xfer && !result.last, result.tx_valid && result.copy_payload && !result.vbus_cut && !result.covert_valid, "first of two results is not a forwarded request")

endmodule

bind usb_pd_message_state_machine_core upd_msm_checker u_upd_msm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
